// File: hdl/mgr_pkg.sv
`default_nettype none
package mgr_pkg;

	typedef enum logic [1:0] {
		MODE_IDENTITY = 2'd0,
		MODE_FULL     = 2'd1,
		MODE_OFFDIAG  = 2'd2,
		MODE_DIAG     = 2'd3
	} mode_t;

	localparam logic [2:0] REG_FLAG = 3'd0;
	localparam logic [2:0] REG_H11  = 3'd1;
	localparam logic [2:0] REG_H21  = 3'd2;
	localparam logic [2:0] REG_H12  = 3'd3;
	localparam logic [2:0] REG_H22  = 3'd4;

	localparam logic [31:0] QNAN_BITS      = 32'h7FC0_0000;
	localparam logic [30:0] INF_MAG        = 31'h7F80_0000;
	localparam logic [31:0] ONE_BITS       = 32'h3F80_0000;
	localparam logic [31:0] MINUS_ONE_BITS = 32'hBF80_0000;

	function automatic logic [6:0] lzc64(input logic [63:0] m);
		logic [6:0] n;
		logic       found;
		n = 7'd64;
		found = 1'b0;
		for (int i = 63; i >= 0; i--) begin
			if (!found && m[i]) begin
				n = 7'(63 - i);
				found = 1'b1;
			end
		end
		return n;
	endfunction

	// m has its leading one at bit 63, be is the biased exponent of that bit
	function automatic logic [31:0] round_pack(input logic s, input logic signed [11:0] be,
		input logic [63:0] m);
		logic [63:0] ms;
		logic [11:0] sh;
		logic [11:0] bex;
		logic [23:0] q;
		logic [39:0] rem;
		logic [24:0] qr;
		logic [32:0] r;
		ms = m;
		bex = be;
		sh = 12'd0;
		if (be < 12'sd1) begin
			sh = 12'(12'sd1 - be);
			if (sh >= 12'd64)
				ms = 64'd1;
			else
				ms = (m >> sh) | {63'd0, |(m & ((64'd1 << sh) - 64'd1))};
			bex = 12'd1;
		end
		q = ms[63:40];
		rem = ms[39:0];
		qr = {1'b0, q} + (((rem > 40'h80_0000_0000) ||
			(rem == 40'h80_0000_0000 && q[0])) ? 25'd1 : 25'd0);
		r = ({21'd0, 12'(bex - 12'd1)} << 23) + {8'd0, qr};
		if (r >= {2'b00, INF_MAG})
			return {s, INF_MAG};
		return {s, r[30:0]};
	endfunction

endpackage
`default_nettype wire

// File: hdl/mgr_if.sv
`default_nettype none
interface mgr_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] x_value;
	logic [31:0] y_value;
	logic        last_in;
	modport source (output valid, x_value, y_value, last_in, input ready);
	modport sink (input valid, x_value, y_value, last_in, output ready);
endinterface

interface mgr_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] x_rotated;
	logic [31:0] y_rotated;
	logic        last_out;
	modport source (output valid, x_rotated, y_rotated, last_out, input ready);
	modport sink (input valid, x_rotated, y_rotated, last_out, output ready);
endinterface
`default_nettype wire

// File: hdl/mgr_fmul.sv
`default_nettype none
module mgr_fmul (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [31:0] a,
	input  wire logic [31:0] b,
	output logic      [31:0] p
);
	logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b, sgn;
	logic        spec;
	logic [31:0] spec_val;
	logic [23:0] ma, mb;
	logic signed [11:0] ea, eb;

	logic        spec_s1, sign_s1;
	logic [31:0] spec_val_s1;
	logic [47:0] prod_s1;
	logic signed [11:0] exp_s1;

	logic        spec_s2, sign_s2;
	logic [31:0] spec_val_s2;
	logic [63:0] norm_s2;
	logic signed [11:0] be_s2;
	logic [6:0]  lz;

	logic [31:0] res_s3;

	always_comb begin
		nan_a = a[30:0] > mgr_pkg::INF_MAG;
		nan_b = b[30:0] > mgr_pkg::INF_MAG;
		inf_a = a[30:0] == mgr_pkg::INF_MAG;
		inf_b = b[30:0] == mgr_pkg::INF_MAG;
		zero_a = a[30:0] == 31'd0;
		zero_b = b[30:0] == 31'd0;
		sgn = a[31] ^ b[31];
		spec = 1'b1;
		if (nan_a || nan_b)
			spec_val = mgr_pkg::QNAN_BITS;
		else if (inf_a || inf_b)
			spec_val = (zero_a || zero_b) ? mgr_pkg::QNAN_BITS : {sgn, mgr_pkg::INF_MAG};
		else if (zero_a || zero_b)
			spec_val = {sgn, 31'd0};
		else begin
			spec_val = 32'd0;
			spec = 1'b0;
		end
		ma = {|a[30:23], a[22:0]};
		mb = {|b[30:23], b[22:0]};
		ea = (a[30:23] == 8'd0) ? -12'sd149 : $signed({4'd0, a[30:23]}) - 12'sd150;
		eb = (b[30:23] == 8'd0) ? -12'sd149 : $signed({4'd0, b[30:23]}) - 12'sd150;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			spec_s1 <= spec;
			spec_val_s1 <= spec_val;
			sign_s1 <= sgn;
			prod_s1 <= ma * mb;
			exp_s1 <= ea + eb;
		end
	end

	assign lz = mgr_pkg::lzc64({prod_s1, 16'd0});

	always_ff @(posedge clk) begin
		if (en) begin
			spec_s2 <= spec_s1;
			spec_val_s2 <= spec_val_s1;
			sign_s2 <= sign_s1;
			norm_s2 <= {prod_s1, 16'd0} << lz;
			be_s2 <= exp_s1 + 12'sd174 - $signed({5'd0, lz});
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			res_s3 <= spec_s2 ? spec_val_s2 : mgr_pkg::round_pack(sign_s2, be_s2, norm_s2);
	end

	assign p = res_s3;
endmodule
`default_nettype wire

// File: hdl/mgr_fadd.sv
`default_nettype none
module mgr_fadd (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [31:0] a,
	input  wire logic [31:0] b,
	output logic      [31:0] s
);
	logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
	logic        spec, sgn, sx, sy;
	logic [31:0] spec_val;
	logic [23:0] ma, mb, mx, my;
	logic signed [11:0] ea, eb, ex, ey;
	logic [11:0] d;
	logic [63:0] wx, wy, wys, sum;

	logic        spec_s4, sign_s4;
	logic [31:0] spec_val_s4;
	logic [63:0] m_s4;
	logic signed [11:0] e_s4;

	logic        spec_s5, sign_s5;
	logic [31:0] spec_val_s5;
	logic [63:0] norm_s5;
	logic signed [11:0] be_s5;
	logic [6:0]  lz;

	logic [31:0] res_s6;

	always_comb begin
		nan_a = a[30:0] > mgr_pkg::INF_MAG;
		nan_b = b[30:0] > mgr_pkg::INF_MAG;
		inf_a = a[30:0] == mgr_pkg::INF_MAG;
		inf_b = b[30:0] == mgr_pkg::INF_MAG;
		zero_a = a[30:0] == 31'd0;
		zero_b = b[30:0] == 31'd0;
		spec = 1'b1;
		if (nan_a || nan_b)
			spec_val = mgr_pkg::QNAN_BITS;
		else if (inf_a && inf_b)
			spec_val = (a[31] == b[31]) ? a : mgr_pkg::QNAN_BITS;
		else if (inf_a)
			spec_val = a;
		else if (inf_b)
			spec_val = b;
		else if (zero_a && zero_b)
			spec_val = {a[31] & b[31], 31'd0};
		else if (zero_a)
			spec_val = b;
		else if (zero_b)
			spec_val = a;
		else begin
			spec_val = 32'd0;
			spec = 1'b0;
		end
		ma = {|a[30:23], a[22:0]};
		mb = {|b[30:23], b[22:0]};
		ea = (a[30:23] == 8'd0) ? -12'sd149 : $signed({4'd0, a[30:23]}) - 12'sd150;
		eb = (b[30:23] == 8'd0) ? -12'sd149 : $signed({4'd0, b[30:23]}) - 12'sd150;
		if (eb > ea) begin
			mx = mb; ex = eb; sx = b[31];
			my = ma; ey = ea; sy = a[31];
		end else begin
			mx = ma; ex = ea; sx = a[31];
			my = mb; ey = eb; sy = b[31];
		end
		d = 12'(ex - ey);
		wx = {2'd0, mx, 38'd0};
		wy = {2'd0, my, 38'd0};
		if (d >= 12'd62)
			wys = 64'd1;
		else
			wys = (wy >> d) | {63'd0, |(wy & ((64'd1 << d) - 64'd1))};
		if (sx == sy) begin
			sum = wx + wys;
			sgn = sx;
		end else if (wx >= wys) begin
			sum = wx - wys;
			sgn = sx;
		end else begin
			sum = wys - wx;
			sgn = sy;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			spec_s4 <= spec || (sum == 64'd0);
			spec_val_s4 <= spec ? spec_val : 32'd0;
			sign_s4 <= sgn;
			m_s4 <= sum;
			e_s4 <= ex - 12'sd38;
		end
	end

	assign lz = mgr_pkg::lzc64(m_s4);

	always_ff @(posedge clk) begin
		if (en) begin
			spec_s5 <= spec_s4;
			spec_val_s5 <= spec_val_s4;
			sign_s5 <= sign_s4;
			norm_s5 <= m_s4 << lz;
			be_s5 <= e_s4 + 12'sd190 - $signed({5'd0, lz});
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			res_s6 <= spec_s5 ? spec_val_s5 : mgr_pkg::round_pack(sign_s5, be_s5, norm_s5);
	end

	assign s = res_s6;
endmodule
`default_nettype wire

// File: hdl/modified_givens_rotation.sv
`default_nettype none
// Modified Givens rotation (srotm) on binary32 pairs: x' = h11*x + h12*y, y' = h21*x + h22*y,
// each multiply and add rounded to nearest even, NaN results as the one quiet NaN 0x7FC00000.
// flag_mode picks identity, full, off-diagonal (h11 = h22 = 1) or diagonal (h12 = 1,
// h21 = -1). Accepts one pair per cycle unless the output stalls; each result passes the 3-stage
// multiply and 3-stage add pipelines. When the output is not taken the whole pipeline holds.
// Registers must be written over APB only while the block is idle; the block does not enforce it.
module modified_givens_rotation (
	input  wire logic        clk,
	input  wire logic        arst_n,
	mgr_in_if.sink           in_pair,
	mgr_out_if.source        out_pair,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);
	localparam int DEPTH = 6;

	mgr_pkg::mode_t flag_mode_q;
	logic [31:0] h11_q, h21_q, h12_q, h22_q;
	logic [31:0] a11, a12, a21, a22;
	logic [31:0] p11, p12, p21, p22, sx, sy;
	logic        adv;
	logic [2:0]  reg_idx;

	logic [DEPTH-1:0] vld_s;
	logic [DEPTH-1:0] last_s;
	logic [DEPTH-1:0] byp_s;
	logic [31:0]      xin_s [DEPTH];
	logic [31:0]      yin_s [DEPTH];

	assign pready = 1'b1;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_mode_q <= mgr_pkg::MODE_IDENTITY;
			h11_q <= 32'd0;
			h21_q <= 32'd0;
			h12_q <= 32'd0;
			h22_q <= 32'd0;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				mgr_pkg::REG_FLAG: flag_mode_q <= mgr_pkg::mode_t'(pwdata[1:0]);
				mgr_pkg::REG_H11:  h11_q <= pwdata;
				mgr_pkg::REG_H21:  h21_q <= pwdata;
				mgr_pkg::REG_H12:  h12_q <= pwdata;
				mgr_pkg::REG_H22:  h22_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			mgr_pkg::REG_FLAG: prdata = {30'd0, flag_mode_q};
			mgr_pkg::REG_H11:  prdata = h11_q;
			mgr_pkg::REG_H21:  prdata = h21_q;
			mgr_pkg::REG_H12:  prdata = h12_q;
			mgr_pkg::REG_H22:  prdata = h22_q;
			default:           prdata = 32'd0;
		endcase
	end

	always_comb begin
		a11 = h11_q;
		a12 = h12_q;
		a21 = h21_q;
		a22 = h22_q;
		if (flag_mode_q == mgr_pkg::MODE_OFFDIAG) begin
			a11 = mgr_pkg::ONE_BITS;
			a22 = mgr_pkg::ONE_BITS;
		end
		if (flag_mode_q == mgr_pkg::MODE_DIAG) begin
			a12 = mgr_pkg::ONE_BITS;
			a21 = mgr_pkg::MINUS_ONE_BITS;
		end
	end

	assign adv = !vld_s[DEPTH-1] || out_pair.ready;
	assign in_pair.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s <= '0;
		else if (adv)
			vld_s <= {vld_s[DEPTH-2:0], in_pair.valid};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s <= {last_s[DEPTH-2:0], in_pair.last_in};
			byp_s <= {byp_s[DEPTH-2:0], flag_mode_q == mgr_pkg::MODE_IDENTITY};
			xin_s[0] <= in_pair.x_value;
			yin_s[0] <= in_pair.y_value;
			for (int i = 1; i < DEPTH; i++) begin
				xin_s[i] <= xin_s[i-1];
				yin_s[i] <= yin_s[i-1];
			end
		end
	end

	mgr_fmul u_m11 (.clk(clk), .en(adv), .a(a11), .b(in_pair.x_value), .p(p11));
	mgr_fmul u_m12 (.clk(clk), .en(adv), .a(a12), .b(in_pair.y_value), .p(p12));
	mgr_fmul u_m21 (.clk(clk), .en(adv), .a(a21), .b(in_pair.x_value), .p(p21));
	mgr_fmul u_m22 (.clk(clk), .en(adv), .a(a22), .b(in_pair.y_value), .p(p22));

	mgr_fadd u_ax (.clk(clk), .en(adv), .a(p11), .b(p12), .s(sx));
	mgr_fadd u_ay (.clk(clk), .en(adv), .a(p21), .b(p22), .s(sy));

	assign out_pair.valid = vld_s[DEPTH-1];
	assign out_pair.last_out = last_s[DEPTH-1];
	assign out_pair.x_rotated = byp_s[DEPTH-1] ? xin_s[DEPTH-1] : sx;
	assign out_pair.y_rotated = byp_s[DEPTH-1] ? yin_s[DEPTH-1] : sy;
endmodule
`default_nettype wire

// File: sim/mgr_checker.sv
`timescale 1ns / 100ps
`default_nettype none
module mgr_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic [31:0] x_value,
	input  wire logic [31:0] y_value,
	input  wire logic        last_in,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic [31:0] x_rotated,
	input  wire logic [31:0] y_rotated,
	input  wire logic        last_out,
	input  wire mgr_pkg::mode_t mode,
	input  wire logic [31:0] h11,
	input  wire logic [31:0] h21,
	input  wire logic [31:0] h12,
	input  wire logic [31:0] h22,
	output int               fail_count,
	output int               pending
);
	typedef struct packed {
		logic [31:0] xr;
		logic [31:0] yr;
		logic        last;
	} pair_t;

	pair_t rotated_q[$];

	function automatic bit f_nan(logic [31:0] v);
		return v[30:0] > 31'h7F80_0000;
	endfunction
	function automatic bit f_inf(logic [31:0] v);
		return v[30:0] == 31'h7F80_0000;
	endfunction
	function automatic bit f_zero(logic [31:0] v);
		return v[30:0] == 31'd0;
	endfunction

	function automatic void f_split(logic [31:0] v, output logic [63:0] m, output int e);
		if (v[30:23] == 8'd0) begin
			m = {41'd0, v[22:0]};
			e = -149;
		end else begin
			m = {40'd0, 1'b1, v[22:0]};
			e = int'(v[30:23]) - 150;
		end
	endfunction

	function automatic logic [31:0] f_round(logic s, int e, logic [63:0] m);
		int be;
		int sh;
		logic [63:0] q;
		logic [63:0] rem;
		logic [63:0] half;
		logic [63:0] r;
		if (m[63]) begin
			m = (m >> 1) | {63'd0, m[0]};
			e++;
		end
		while (m[63:62] == 2'b00) begin
			m = m << 1;
			e--;
		end
		be = e + 189;
		sh = 39;
		if (be < 1) begin
			sh += 1 - be;
			be = 1;
		end
		if (sh >= 64) q = 0;
		else begin
			q = m >> sh;
			rem = m & ((64'd1 << sh) - 64'd1);
			half = 64'd1 << (sh - 1);
			if (rem > half || (rem == half && q[0])) q++;
		end
		r = (64'(be - 1) << 23) + q;
		if (r >= 64'h7F80_0000) return {s, 31'h7F80_0000};
		return {s, r[30:0]};
	endfunction

	function automatic logic [31:0] f_mul(logic [31:0] a, logic [31:0] b);
		logic s;
		logic [63:0] ma, mb;
		int ea, eb;
		s = a[31] ^ b[31];
		if (f_nan(a) || f_nan(b)) return mgr_pkg::QNAN_BITS;
		if (f_inf(a) || f_inf(b)) begin
			if (f_zero(a) || f_zero(b)) return mgr_pkg::QNAN_BITS;
			return {s, 31'h7F80_0000};
		end
		if (f_zero(a) || f_zero(b)) return {s, 31'd0};
		f_split(a, ma, ea);
		f_split(b, mb, eb);
		return f_round(s, ea + eb, ma * mb);
	endfunction

	function automatic logic [31:0] f_add(logic [31:0] a, logic [31:0] b);
		logic sa, sb, s;
		logic [63:0] ma, mb, m, t;
		int ea, eb, d;
		sa = a[31];
		sb = b[31];
		if (f_nan(a) || f_nan(b)) return mgr_pkg::QNAN_BITS;
		if (f_inf(a) && f_inf(b)) return (sa == sb) ? a : mgr_pkg::QNAN_BITS;
		if (f_inf(a)) return a;
		if (f_inf(b)) return b;
		if (f_zero(a) && f_zero(b)) return {sa & sb, 31'd0};
		if (f_zero(a)) return b;
		if (f_zero(b)) return a;
		f_split(a, ma, ea);
		f_split(b, mb, eb);
		if (eb > ea) begin
			t = ma; ma = mb; mb = t;
			d = ea; ea = eb; eb = d;
			s = sa; sa = sb; sb = s;
		end
		d = ea - eb;
		ma = ma << 38;
		mb = mb << 38;
		if (d >= 62) mb = 64'd1;
		else if (d > 0) begin
			t = mb & ((64'd1 << d) - 64'd1);
			mb = (mb >> d) | {63'd0, t != 0};
		end
		if (sa == sb) begin
			m = ma + mb;
			s = sa;
		end else if (ma >= mb) begin
			m = ma - mb;
			s = sa;
		end else begin
			m = mb - ma;
			s = sb;
		end
		if (m == 0) return 32'd0;
		return f_round(s, ea - 38, m);
	endfunction

	function automatic pair_t rotate(logic [31:0] x, logic [31:0] y, logic l);
		pair_t p;
		logic [31:0] a11, a12, a21, a22;
		a11 = h11; a12 = h12; a21 = h21; a22 = h22;
		p.xr = x;
		p.yr = y;
		p.last = l;
		if (mode != mgr_pkg::MODE_IDENTITY) begin
			if (mode == mgr_pkg::MODE_OFFDIAG) begin
				a11 = mgr_pkg::ONE_BITS;
				a22 = mgr_pkg::ONE_BITS;
			end
			if (mode == mgr_pkg::MODE_DIAG) begin
				a12 = mgr_pkg::ONE_BITS;
				a21 = mgr_pkg::MINUS_ONE_BITS;
			end
			p.xr = f_add(f_mul(a11, x), f_mul(a12, y));
			p.yr = f_add(f_mul(a21, x), f_mul(a22, y));
		end
		return p;
	endfunction

	assign pending = rotated_q.size();

	always @(posedge clk) begin
		pair_t e;
		if (arst_n) begin
			if (in_valid && in_ready)
				rotated_q.push_back(rotate(x_value, y_value, last_in));
			if (out_valid && out_ready) begin
				if (rotated_q.size() == 0) begin
					$error("unexpected transfer x_rotated %h", x_rotated);
					fail_count++;
				end else begin
					e = rotated_q.pop_front();
					if (x_rotated !== e.xr) begin
						$error("x_rotated exp %h got %h", e.xr, x_rotated);
						fail_count++;
					end
					if (y_rotated !== e.yr) begin
						$error("y_rotated exp %h got %h", e.yr, y_rotated);
						fail_count++;
					end
					if (last_out !== e.last) begin
						$error("last_out exp %b got %b", e.last, last_out);
						fail_count++;
					end
				end
			end
		end
	end
endmodule
`default_nettype wire

// File: sim/tb_top.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [4:0] paddr = 0;
	logic [31:0] pwdata = 0;
	logic [31:0] prdata;
	logic pready;
	int fail_count, pending;
	int cycles = 0;
	int idle_pct = 0, stall_pct = 0;
	mgr_pkg::mode_t mode = mgr_pkg::MODE_IDENTITY;
	logic [31:0] h11 = 0, h21 = 0, h12 = 0, h22 = 0;

	mgr_in_if in_pair ();
	mgr_out_if out_pair ();

	modified_givens_rotation dut (
		.clk(clk), .arst_n(arst_n), .in_pair(in_pair.sink), .out_pair(out_pair.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready)
	);

	mgr_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_pair.valid), .in_ready(in_pair.ready), .x_value(in_pair.x_value),
		.y_value(in_pair.y_value), .last_in(in_pair.last_in),
		.out_valid(out_pair.valid), .out_ready(out_pair.ready),
		.x_rotated(out_pair.x_rotated), .y_rotated(out_pair.y_rotated),
		.last_out(out_pair.last_out),
		.mode(mode), .h11(h11), .h21(h21), .h12(h12), .h22(h22),
		.fail_count(fail_count), .pending(pending)
	);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	initial begin
		in_pair.valid = 0;
		in_pair.x_value = 0;
		in_pair.y_value = 0;
		in_pair.last_in = 0;
		out_pair.ready = 0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 400000) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	always @(negedge clk)
		out_pair.ready <= arst_n && ($urandom_range(99) >= stall_pct);

	task automatic reg_write(logic [2:0] idx, logic [31:0] val);
		@(negedge clk);
		psel <= 1; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		case (idx)
			mgr_pkg::REG_FLAG: mode = mgr_pkg::mode_t'(val[1:0]);
			mgr_pkg::REG_H11: h11 = val;
			mgr_pkg::REG_H21: h21 = val;
			mgr_pkg::REG_H12: h12 = val;
			mgr_pkg::REG_H22: h22 = val;
			default: ;
		endcase
	endtask

	task automatic drain();
		in_pair.valid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	function automatic logic [31:0] pick_float();
		case ($urandom_range(11))
			0: return 32'h0000_0000;
			1: return 32'h8000_0000;
			2: return {1'($urandom_range(1)), 31'h7F80_0000};
			3: return {1'($urandom_range(1)), 8'hFF, 23'($urandom)};
			4: return {1'($urandom_range(1)), 8'h00, 23'($urandom)};
			5: return {1'($urandom_range(1)), 8'hFE, 23'($urandom)};
			6: return $urandom;
			default: return {1'($urandom_range(1)), 8'($urandom_range(100, 154)),
				23'($urandom)};
		endcase
	endfunction

	task automatic send(logic [31:0] x, logic [31:0] y, logic l);
		while ($urandom_range(99) < idle_pct) begin
			in_pair.valid <= 0;
			@(negedge clk);
		end
		in_pair.valid <= 1;
		in_pair.x_value <= x;
		in_pair.y_value <= y;
		in_pair.last_in <= l;
		@(posedge clk);
		while (!in_pair.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic config_set(mgr_pkg::mode_t m);
		reg_write(mgr_pkg::REG_FLAG, 32'(m));
		reg_write(mgr_pkg::REG_H11, pick_float());
		reg_write(mgr_pkg::REG_H21, pick_float());
		reg_write(mgr_pkg::REG_H12, pick_float());
		reg_write(mgr_pkg::REG_H22, pick_float());
	endtask

	initial begin
		logic [31:0] dir_x[12];
		logic [31:0] dir_y[12];
		dir_x = '{32'h0, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000, 32'h7FFF_FFFF,
			32'h0000_0001, 32'h807F_FFFF, 32'h7F7F_FFFF, 32'hFFFF_FFFF, 32'h3F80_0000,
			32'h0080_0000, 32'hBF80_0000};
		dir_y = '{32'h8000_0000, 32'h8000_0000, 32'hFF80_0000, 32'h0, 32'h3F80_0000,
			32'h8000_0001, 32'h007F_FFFF, 32'h7F7F_FFFF, 32'h0000_0000, 32'hBF80_0000,
			32'h8080_0000, 32'h3F80_0000};
		repeat (6) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		for (int m = 0; m < 4; m++) begin
			reg_write(mgr_pkg::REG_FLAG, m);
			reg_write(mgr_pkg::REG_H11, m == 1 ? 32'h7F80_0000 : 32'h3F80_0000);
			reg_write(mgr_pkg::REG_H21, m == 2 ? 32'hFFFF_FFFF : 32'h8000_0000);
			reg_write(mgr_pkg::REG_H12, 32'h7F7F_FFFF);
			reg_write(mgr_pkg::REG_H22, m == 3 ? 32'h0000_0001 : 32'h0);
			for (int i = 0; i < 6; i++)
				send(dir_x[(i + 3 * m) % 12], dir_y[(i + 3 * m) % 12], i[0]);
			drain();
		end
		for (int ph = 0; ph < 16; ph++) begin
			case (ph % 4)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 88; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 88; end
				default: begin idle_pct = 29; stall_pct = 29; end
			endcase
			config_set(mgr_pkg::mode_t'(ph % 4));
			for (int i = 0; i < 78; i++) begin
				if (i == 40) drain();
				send(pick_float(), pick_float(), 1'($urandom_range(1)));
			end
			drain();
		end
		if (fail_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule
`default_nettype wire
